### design/wu_line_pkg.sv
package wu_line_pkg;

  localparam int unsigned Width  = 512;
  localparam int unsigned Height = 512;
  localparam int unsigned CoordW = 9;
  localparam int unsigned AddrW  = 18;
  localparam int unsigned ColW   = 24;
  localparam int unsigned CntW   = 10;
  localparam int unsigned AccW   = 16;

  typedef enum logic [1:0] {
    FuncDraw = 2'd0,
    FuncRead = 2'd1,
    FuncFill = 2'd2,
    FuncNop  = 2'd3
  } func_e;

  // gray level used to order line against background
  function automatic logic [8:0] gray_of(input logic [ColW-1:0] c);
    gray_of = {3'd0, c[7:2]} + {2'd0, c[15:9]} + {4'd0, c[23:19]};
  endfunction

  // one colour channel blended toward the line
  function automatic logic [7:0] blend_ch(input logic [7:0] b, input logic [7:0] l,
                                          input logic [7:0] k);
    logic [7:0]  diff;
    logic [7:0]  base;
    logic [15:0] prod;
    if (b > l) begin
      diff = b - l;
      base = l;
    end else begin
      diff = l - b;
      base = b;
    end
    prod = k * diff;
    blend_ch = prod[15:8] + base;
  endfunction

endpackage

### design/wu_antialiased_line_raster_unit.sv
// Anti-aliased line rasterizer over a 512x512 RGB frame memory.
// Input channel (in_valid_i/in_ready_o) carries one item: func selects draw,
// read, fill or no operation. Output channel (out_valid_o/out_ready_i)
// returns exactly one result per item: pixel_value_o for a read,
// pixels_written_o for a draw, zeros otherwise.
// One item is processed at a time in a single-port synchronous memory.
// Fill writes one entry per cycle. A draw first runs the adjustment
// divider, then for each major-axis step takes one step state, then the
// read, wait, blend and write states for each pixel of the pair; the
// single memory port sets this pace.
// The frame memory is not cleared at reset; pixels are undefined until a
// fill or draw writes them. Reset returns the controller to idle.
// The result sits in an output register; when the receiver stalls, the
// block still accepts the next item and works on it, holding its result
// until the register frees.
module wu_antialiased_line_raster_unit
  import wu_line_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [CoordW-1:0] start_x_i,
  input  logic [CoordW-1:0] start_y_i,
  input  logic [CoordW-1:0] end_x_i,
  input  logic [CoordW-1:0] end_y_i,
  input  logic [ColW-1:0]   colour_i,
  input  logic [CoordW-1:0] pixel_x_i,
  input  logic [CoordW-1:0] pixel_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ColW-1:0]   pixel_value_o,
  output logic [CntW-1:0]   pixels_written_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRdWt  = 4'd1;
  localparam logic [3:0] StFill  = 4'd2;
  localparam logic [3:0] StStart = 4'd3;
  localparam logic [3:0] StDiv   = 4'd4;
  localparam logic [3:0] StStep  = 4'd5;
  localparam logic [3:0] StPxRd  = 4'd6;
  localparam logic [3:0] StPxWt  = 4'd7;
  localparam logic [3:0] StPxWr  = 4'd8;
  localparam logic [3:0] StDone  = 4'd9;

  logic [3:0] state_q, state_d;

  // frame memory
  logic [ColW-1:0] mem [2**AddrW];
  logic            mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [ColW-1:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_q <= mem[mem_addr];
  end

  // item registers
  logic signed [CoordW+1:0] x_q, x_d, y_q, y_d, ex_q, ex_d;
  logic [CoordW-1:0] major_q, major_d, minor_q, minor_d;
  logic [CoordW-1:0] i_q, i_d;
  logic              xmajor_q, xmajor_d, xneg_q, xneg_d, second_q, second_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [AccW:0]     adj_q, adj_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AddrW-1:0]  fill_q, fill_d;
  logic              rd_q, rd_d, rdok_q, rdok_d;

  // result register
  logic            res_valid_q, res_valid_d;
  logic [ColW-1:0] res_pix_q, res_pix_d;
  logic [CntW-1:0] res_cnt_q, res_cnt_d;

  logic div_start, div_done;
  logic [AccW:0] div_quot;

  wu_line_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .minor_i (minor_q),
    .major_i (major_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // pixel under work: primary or its neighbour
  logic signed [CoordW+1:0] px, py;
  logic inside_px;
  always_comb begin
    px = x_q;
    py = y_q;
    if (second_q) begin
      if (xmajor_q) py = y_q + 11'sd1;
      else px = xneg_q ? x_q - 11'sd1 : x_q + 11'sd1;
    end
    inside_px = (px >= 0) && (py >= 0) && (px < 11'sd512) && (py < 11'sd512);
  end

  logic [7:0] w, k;
  logic       darker;
  logic [ColW-1:0] blended;
  always_comb begin
    w = acc_q[AccW-1:8];
    darker = gray_of(col_q) < gray_of(mem_rdata_q);
    k = (darker ^ second_q) ? w : ~w;
    blended = {blend_ch(mem_rdata_q[23:16], col_q[23:16], k),
               blend_ch(mem_rdata_q[15:8],  col_q[15:8],  k),
               blend_ch(mem_rdata_q[7:0],   col_q[7:0],   k)};
  end

  logic [AccW:0] sum;
  logic [CoordW:0] adx;
  logic signed [CoordW+1:0] dxs;

  // controller
  always_comb begin
    state_d = state_q;
    x_d = x_q; y_d = y_q; ex_d = ex_q;
    major_d = major_q; minor_d = minor_q; i_d = i_q;
    xmajor_d = xmajor_q; xneg_d = xneg_q; second_d = second_q;
    col_d = col_q; acc_d = acc_q; adj_d = adj_q; cnt_d = cnt_q;
    fill_d = fill_q; rd_d = rd_q; rdok_d = rdok_q;
    res_valid_d = res_valid_q; res_pix_d = res_pix_q; res_cnt_d = res_cnt_q;
    mem_we = 1'b0;
    mem_addr = {py[CoordW-1:0], px[CoordW-1:0]};
    mem_wdata = blended;
    div_start = 1'b0;
    in_ready_o = 1'b0;
    sum = {1'b0, acc_q} + adj_q;
    dxs = ex_q - x_q;
    adx = dxs[CoordW+1] ? (CoordW+1)'(-dxs) : dxs[CoordW:0];

    if (res_valid_q && out_ready_i) res_valid_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          col_d = colour_i;
          unique case (func_i)
            FuncDraw: begin
              if (start_y_i > end_y_i) begin
                x_d = 11'(end_x_i); y_d = 11'(end_y_i);
                ex_d = 11'(start_x_i);
                minor_d = start_y_i - end_y_i;
              end else begin
                x_d = 11'(start_x_i); y_d = 11'(start_y_i);
                ex_d = 11'(end_x_i);
                minor_d = end_y_i - start_y_i;
              end
              state_d = StStart;
            end
            FuncRead: begin
              x_d = 11'(pixel_x_i); y_d = 11'(pixel_y_i);
              second_d = 1'b0;
              state_d = StRdWt;
              rd_d = 1'b0;
            end
            FuncFill: begin
              fill_d = '0;
              state_d = StFill;
            end
            default: begin
              cnt_d = '0; rdok_d = 1'b0;
              state_d = StDone;
            end
          endcase
        end
      end
      StRdWt: begin
        // address presented this cycle, data next
        if (!rd_q) rd_d = 1'b1;
        else begin
          cnt_d = '0;
          rdok_d = 1'b1;
          rd_d = 1'b0;
          state_d = StDone;
        end
      end
      StFill: begin
        mem_we = 1'b1;
        mem_addr = fill_q;
        mem_wdata = col_q;
        fill_d = fill_q + 1'b1;
        if (&fill_q) begin
          cnt_d = '0; rdok_d = 1'b0;
          state_d = StDone;
        end
      end
      StStart: begin
        // start pixel in line colour, then set up axes (minor holds dy)
        second_d = 1'b0;
        mem_addr = {y_q[CoordW-1:0], x_q[CoordW-1:0]};
        mem_we = 1'b1;
        mem_wdata = col_q;
        cnt_d = CntW'(1);
        xneg_d = dxs[CoordW+1];
        acc_d = '0;
        i_d = CoordW'(1);
        rdok_d = 1'b0;
        if (minor_q > adx[CoordW-1:0]) begin
          xmajor_d = 1'b0;
          major_d = minor_q;
          minor_d = adx[CoordW-1:0];
        end else begin
          xmajor_d = 1'b1;
          major_d = adx[CoordW-1:0];
        end
        if (minor_q == 0 && adx == 0) state_d = StDone;
        else state_d = StDiv;
      end
      StDiv: begin
        if (!rd_q) begin
          div_start = 1'b1;
          rd_d = 1'b1;
        end else if (div_done) begin
          adj_d = div_quot;
          rd_d = 1'b0;
          state_d = StStep;
        end
      end
      StStep: begin
        if (i_q >= major_q) state_d = StDone;
        else begin
          acc_d = sum[AccW-1:0];
          if (xmajor_q) begin
            if (sum[AccW]) y_d = y_q + 11'sd1;
            x_d = xneg_q ? x_q - 11'sd1 : x_q + 11'sd1;
          end else begin
            if (sum[AccW]) x_d = xneg_q ? x_q - 11'sd1 : x_q + 11'sd1;
            y_d = y_q + 11'sd1;
          end
          second_d = 1'b0;
          state_d = StPxRd;
        end
      end
      StPxRd: begin
        if (inside_px) state_d = StPxWt;
        else state_d = StPxWr;
      end
      StPxWt: state_d = StPxWr;
      StPxWr: begin
        if (inside_px) begin
          mem_we = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
        if (!second_q) begin
          second_d = 1'b1;
          state_d = StPxRd;
        end else begin
          second_d = 1'b0;
          i_d = i_q + 1'b1;
          state_d = StStep;
        end
      end
      StDone: begin
        if (!res_valid_q || out_ready_i) begin
          res_valid_d = 1'b1;
          res_cnt_d = cnt_q;
          res_pix_d = (rdok_q && inside_px) ? mem_rdata_q : '0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
      rd_q        <= 1'b0;
      acc_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      rd_q        <= rd_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; ex_q <= ex_d;
    major_q <= major_d; minor_q <= minor_d; i_q <= i_d;
    xmajor_q <= xmajor_d; xneg_q <= xneg_d; second_q <= second_d;
    col_q <= col_d; adj_q <= adj_d; cnt_q <= cnt_d;
    fill_q <= fill_d; rdok_q <= rdok_d;
    res_pix_q <= res_pix_d; res_cnt_q <= res_cnt_d;
  end

  assign out_valid_o      = res_valid_q;
  assign pixel_value_o    = res_pix_q;
  assign pixels_written_o = res_cnt_q;

endmodule

### design/wu_line_div.sv
// radix-2 restoring divider for the accumulator step: (minor << 16) / major
module wu_line_div
  import wu_line_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CoordW-1:0] minor_i,
  input  logic [CoordW-1:0] major_i,
  output logic              done_o,
  output logic [AccW:0]     quot_o
);

  localparam int unsigned NumW = CoordW + AccW;

  logic [NumW-1:0]   num_q, num_d;
  logic [CoordW:0]   rem_q, rem_d;
  logic [CoordW-1:0] den_q, den_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [CoordW+1:0] trial;

  // one quotient bit per cycle, quotient shifts into num
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    trial  = {rem_q, num_q[NumW-1]} - {2'b0, den_q};
    if (start_i) begin
      num_d  = {minor_i, {AccW{1'b0}}};
      rem_d  = '0;
      den_d  = major_i;
      cnt_d  = 5'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[CoordW+1]) begin
        rem_d = trial[CoordW:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[CoordW-1:0], num_q[NumW-1]};
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quot_o = num_d[AccW:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

### design/wu_line_checker.sv
module wu_line_checker
  import wu_line_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [ColW-1:0] pixel_value_o,
  input logic [CntW-1:0] pixels_written_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_value_o)
      && $stable(pixels_written_o))
    else $error("result changed while stalled");

  // a draw result never carries a pixel value
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixels_written_o != '0 |-> pixel_value_o == '0)
    else $error("draw result with pixel value");

  // an accepted item is not followed by a second acceptance in the next cycle
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  // no result right after reset without an item
  a_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result without item");

endmodule

bind wu_antialiased_line_raster_unit wu_line_checker u_checker (.*);

### dv/testbench.sv
module testbench;
  import wu_line_pkg::*;

  typedef struct {
    func_e             func;
    logic [CoordW-1:0] sx, sy, ex, ey;
    logic [ColW-1:0]   colour;
    logic [CoordW-1:0] px, py;
  } raster_req_t;

  typedef struct {
    logic [ColW-1:0] value;
    logic [CntW-1:0] written;
  } raster_rsp_t;

  localparam int unsigned CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  func_e             req_func = FuncNop;
  logic [CoordW-1:0] req_sx = '0, req_sy = '0, req_ex = '0, req_ey = '0;
  logic [ColW-1:0]   req_colour = '0;
  logic [CoordW-1:0] req_px = '0, req_py = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ColW-1:0]   pixel_value;
  logic [CntW-1:0]   pixels_written;

  raster_req_t pending_reqs[$];
  raster_rsp_t expected_rsps[$];
  logic        in_fire = 1'b0;
  int          accepted = 0;
  int          mismatches = 0;
  int          cycles = 0;

  // shadow frame: sparse writes over the last fill colour
  logic [ColW-1:0] shadow_pix[int];
  logic [ColW-1:0] shadow_fill = '0;

  wu_antialiased_line_raster_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (req_func),
    .start_x_i       (req_sx),
    .start_y_i       (req_sy),
    .end_x_i         (req_ex),
    .end_y_i         (req_ey),
    .colour_i        (req_colour),
    .pixel_x_i       (req_px),
    .pixel_y_i       (req_py),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .pixel_value_o   (pixel_value),
    .pixels_written_o(pixels_written)
  );

  // clock and reset
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  function automatic bit on_frame(int x, int y);
    return x >= 0 && y >= 0 && x < Width && y < Height;
  endfunction

  function automatic logic [ColW-1:0] shadow_rd(int x, int y);
    int idx;
    idx = y * Width + x;
    return shadow_pix.exists(idx) ? shadow_pix[idx] : shadow_fill;
  endfunction

  function automatic int luma(logic [ColW-1:0] c);
    return (c[7:0] >> 2) + (c[15:8] >> 1) + (c[23:16] >> 3);
  endfunction

  function automatic logic [ColW-1:0] mix(logic [ColW-1:0] bg, logic [ColW-1:0] ln, int k);
    logic [ColW-1:0] res;
    int b, l, v;
    for (int s = 0; s < 24; s += 8) begin
      b = bg[s +: 8];
      l = ln[s +: 8];
      v = (b > l) ? (((k * (b - l)) >> 8) + l) : (((k * (l - b)) >> 8) + b);
      res[s +: 8] = v[7:0];
    end
    return res;
  endfunction

  function automatic int blend_pixel(int x, int y, logic [ColW-1:0] ln, bit primary, int w);
    logic [ColW-1:0] bg;
    bit darker;
    int k;
    if (!on_frame(x, y)) return 0;
    bg = shadow_rd(x, y);
    darker = luma(ln) < luma(bg);
    if (primary) k = darker ? w : (w ^ 255);
    else k = darker ? (w ^ 255) : w;
    shadow_pix[y * Width + x] = mix(bg, ln, k);
    return 1;
  endfunction

  // anti-aliased line: returns number of pixel writes
  function automatic int raster_line(int x0, int y0, int x1, int y1, logic [ColW-1:0] ln);
    int cnt, t, dx, dy, xdir, major, minor, w;
    bit xmajor, carry;
    logic [31:0] adj, sum;
    logic [AccW-1:0] acc;
    cnt = 0;
    if (y0 > y1) begin
      t = y0; y0 = y1; y1 = t;
      t = x0; x0 = x1; x1 = t;
    end
    if (on_frame(x0, y0)) begin
      shadow_pix[y0 * Width + x0] = ln;
      cnt++;
    end
    dx = x1 - x0;
    xdir = 1;
    if (dx < 0) begin
      xdir = -1;
      dx = -dx;
    end
    dy = y1 - y0;
    acc = '0;
    xmajor = !(dy > dx);
    major = xmajor ? dx : dy;
    minor = xmajor ? dy : dx;
    if (major == 0) return cnt;
    adj = (32'(minor) << 16) / 32'(major);
    for (int i = 1; i < major; i++) begin
      sum = 32'(acc) + adj;
      carry = sum > 32'hFFFF;
      acc = sum[AccW-1:0];
      if (xmajor) begin
        if (carry) y0++;
        x0 += xdir;
      end else begin
        if (carry) x0 += xdir;
        y0++;
      end
      w = acc >> 8;
      cnt += blend_pixel(x0, y0, ln, 1'b1, w);
      if (xmajor) cnt += blend_pixel(x0, y0 + 1, ln, 1'b0, w);
      else cnt += blend_pixel(x0 + xdir, y0, ln, 1'b0, w);
    end
    return cnt;
  endfunction

  function automatic raster_rsp_t predict_raster(raster_req_t r);
    raster_rsp_t o;
    o.value = '0;
    o.written = '0;
    case (r.func)
      FuncDraw: o.written = CntW'(raster_line(r.sx, r.sy, r.ex, r.ey, r.colour));
      FuncRead: o.value = shadow_rd(r.px, r.py);
      FuncFill: begin
        shadow_pix.delete();
        shadow_fill = r.colour;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic bit calm_phase();
    return accepted >= 120 && accepted < 180;
  endfunction

  // driver: next transaction at the falling edge
  always @(negedge clk) begin
    raster_req_t r;
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending_reqs.size() > 0 && (calm_phase() || $urandom_range(99) >= 12)) begin
          r = pending_reqs.pop_front();
          req_func   <= r.func;
          req_sx     <= r.sx;
          req_sy     <= r.sy;
          req_ex     <= r.ex;
          req_ey     <= r.ey;
          req_colour <= r.colour;
          req_px     <= r.px;
          req_py     <= r.py;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm_phase() || $urandom_range(99) >= 12;
    end
  end

  // monitor: predict on accepted requests, check results
  always @(posedge clk) begin
    raster_req_t r;
    raster_rsp_t exp_rsp;
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (in_valid && in_ready) begin
        r = '{req_func, req_sx, req_sy, req_ex, req_ey, req_colour, req_px, req_py};
        expected_rsps.push_back(predict_raster(r));
        accepted <= accepted + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result value=%h written=%0d",
                                         pixel_value, pixels_written);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (pixel_value !== exp_rsp.value || pixels_written !== exp_rsp.written) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: value exp %h got %h, written exp %0d got %0d",
                       exp_rsp.value, pixel_value, exp_rsp.written, pixels_written);
          end
        end
      end
      if (cycles > CycleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic raster_req_t mk(func_e f, int sx, int sy, int ex, int ey,
                                     logic [ColW-1:0] c, int px, int py);
    raster_req_t r;
    r.func = f;
    r.sx = CoordW'(sx); r.sy = CoordW'(sy); r.ex = CoordW'(ex); r.ey = CoordW'(ey);
    r.colour = c;
    r.px = CoordW'(px); r.py = CoordW'(py);
    return r;
  endfunction

  function automatic int clampc(int v);
    return v < 0 ? 0 : (v > 511 ? 511 : v);
  endfunction

  task automatic add_random(int n);
    int sel, sx, sy, ex, ey, span;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      sx = $urandom_range(511);
      sy = $urandom_range(511);
      if (sel < 50) begin
        // mostly short lines, a few long ones
        span = ($urandom_range(19) == 0) ? 511 : 40;
        ex = clampc(sx + $urandom_range(2 * span) - span);
        ey = clampc(sy + $urandom_range(2 * span) - span);
        pending_reqs.push_back(mk(FuncDraw, sx, sy, ex, ey, ColW'($urandom),
                                  $urandom_range(511), $urandom_range(511)));
        // read back near the fresh line
        pending_reqs.push_back(mk(FuncRead, $urandom_range(511), $urandom_range(511),
                                  $urandom_range(511), $urandom_range(511), ColW'($urandom),
                                  clampc(sx + $urandom_range(4) - 2),
                                  clampc(sy + $urandom_range(4) - 2)));
      end else if (sel < 90) begin
        pending_reqs.push_back(mk(FuncRead, sx, sy, $urandom_range(511),
                                  $urandom_range(511), ColW'($urandom),
                                  $urandom_range(511), $urandom_range(511)));
      end else begin
        pending_reqs.push_back(mk(FuncNop, sx, sy, $urandom_range(511),
                                  $urandom_range(511), ColW'($urandom),
                                  $urandom_range(511), $urandom_range(511)));
      end
    end
  endtask

  initial begin
    // directed: fill first so no unwritten pixel is ever read
    pending_reqs.push_back(mk(FuncFill, 0, 0, 0, 0, ColW'($urandom), 0, 0));
    pending_reqs.push_back(mk(FuncRead, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FuncRead, 511, 511, 511, 511, 24'hFFFFFF, 511, 511));
    // zero-length line
    pending_reqs.push_back(mk(FuncDraw, 100, 100, 100, 100, 24'h123456, 0, 0));
    // horizontal and vertical
    pending_reqs.push_back(mk(FuncDraw, 10, 20, 60, 20, 24'hFFFFFF, 0, 0));
    pending_reqs.push_back(mk(FuncDraw, 30, 80, 30, 10, 24'h000000, 0, 0));
    // diagonal, steep, reversed and leftward
    pending_reqs.push_back(mk(FuncDraw, 200, 200, 250, 250, 24'h80FF10, 0, 0));
    pending_reqs.push_back(mk(FuncDraw, 300, 300, 310, 360, 24'h0000FF, 0, 0));
    pending_reqs.push_back(mk(FuncDraw, 420, 90, 380, 60, 24'hFF00FF, 0, 0));
    pending_reqs.push_back(mk(FuncDraw, 150, 400, 100, 470, 24'h00FF00, 0, 0));
    // lines along the frame edges; bottom-edge neighbors fall outside the frame
    pending_reqs.push_back(mk(FuncDraw, 0, 0, 3, 80, 24'hFFFFFF, 0, 0));
    pending_reqs.push_back(mk(FuncDraw, 511, 0, 508, 90, 24'h000000, 0, 0));
    pending_reqs.push_back(mk(FuncDraw, 400, 511, 470, 511, 24'hABCDEF, 0, 0));
    pending_reqs.push_back(mk(FuncDraw, 100, 509, 300, 511, 24'h0F0F0F, 0, 0));
    pending_reqs.push_back(mk(FuncRead, 0, 0, 0, 0, 0, 1, 1));
    pending_reqs.push_back(mk(FuncRead, 0, 0, 0, 0, 0, 60, 20));
    pending_reqs.push_back(mk(FuncRead, 0, 0, 0, 0, 0, 225, 225));
    // longest lines
    pending_reqs.push_back(mk(FuncDraw, 0, 0, 511, 511, 24'hFFFFFF, 511, 511));
    pending_reqs.push_back(mk(FuncDraw, 511, 0, 0, 511, 24'h000000, 0, 0));
    pending_reqs.push_back(mk(FuncRead, 0, 0, 0, 0, 0, 256, 255));
    pending_reqs.push_back(mk(FuncNop, 511, 511, 511, 511, 24'hFFFFFF, 511, 511));
    pending_reqs.push_back(mk(FuncFill, 0, 0, 0, 0, 24'hFFFFFF, 0, 0));
    pending_reqs.push_back(mk(FuncDraw, 5, 5, 90, 40, 24'h000000, 0, 0));
    pending_reqs.push_back(mk(FuncRead, 0, 0, 0, 0, 0, 47, 23));
    add_random(90);
    pending_reqs.push_back(mk(FuncFill, 0, 0, 0, 0, ColW'($urandom), 0, 0));
    add_random(90);

    wait (rst_n);
    wait (pending_reqs.size() == 0 && !in_valid && expected_rsps.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
